// ===== sv/vbrt_pkg.sv =====
`default_nettype none
package vbrt_pkg;

   // Fixed geometry of a request.
   localparam logic [31:0] HEADER_BYTES = 32'd16;
   localparam int unsigned SECTOR_SHIFT = 9;
   localparam int unsigned ID_SHIFT = 32;
   localparam int unsigned COUNT_W = 32 - SECTOR_SHIFT + 1;

   // Input operation codes.
   localparam logic [2:0] OP_SUBMIT        = 3'd0;
   localparam logic [2:0] OP_COMPLETE_OK   = 3'd1;
   localparam logic [2:0] OP_COMPLETE_READ = 3'd2;
   localparam logic [2:0] OP_FAIL          = 3'd3;
   localparam logic [2:0] OP_DEVICE_RESET  = 3'd4;

   // Result action codes.
   localparam logic [2:0] ACT_IGNORED     = 3'd0;
   localparam logic [2:0] ACT_NEEDS_RESET = 3'd1;
   localparam logic [2:0] ACT_IMMEDIATE   = 3'd2;
   localparam logic [2:0] ACT_EXPORTED    = 3'd3;
   localparam logic [2:0] ACT_COMPLETED   = 3'd4;
   localparam logic [2:0] ACT_RESET_DONE  = 3'd5;

   // Status byte values.
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_IO_ERROR    = 2'd1;
   localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

   // Exported request kinds.
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   // Header request types.
   localparam logic [31:0] HTYPE_READ  = 32'd0;
   localparam logic [31:0] HTYPE_WRITE = 32'd1;
   localparam logic [31:0] HTYPE_FLUSH = 32'd4;

   // Configuration register indexes.
   localparam logic CSR_CAPACITY     = 1'b0;
   localparam logic CSR_DEVICE_INDEX = 1'b1;

   // Command queue between the classifier and the executor.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_IGNORE,
      CMD_BAD_SUBMIT,
      CMD_SUBMIT,
      CMD_COMPLETE,
      CMD_RESET
   } cmd_kind_type;

   typedef struct packed {
      logic        enable;
      logic        index;
      logic [63:0] data;
   } csr_write_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         beyond;
      logic         unsupported;
      logic         is_read;
      logic [1:0]   request_kind;
      logic [63:0]  sector;
      logic [31:0]  data_length;
      logic [15:0]  descriptor;
      logic [31:0]  status_position;
      logic         is_fail;
      logic         read_data_ok;
      logic [63:0]  completion_id;
      logic [31:0]  completion_length;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] request_id;
      logic [1:0]  request_kind;
      logic [63:0] request_sector;
      logic [31:0] data_length;
      logic [15:0] used_descriptor;
      logic [31:0] status_position;
      logic [1:0]  status_code;
      logic [31:0] used_length;
   } rsp_type;

endpackage
`default_nettype wire

// ===== sv/vbrt_req_if.sv =====
`default_nettype none
interface vbrt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [3:0]  queue_index;
   logic [31:0] readable_length;
   logic [31:0] writable_length;
   logic [15:0] descriptor_index;
   logic [31:0] header_type;
   logic [63:0] header_sector;
   logic [63:0] completion_id;
   logic        data_present;
   logic [31:0] completion_length;

   modport source (
      output valid, op, queue_index, readable_length, writable_length, descriptor_index,
             header_type, header_sector, completion_id, data_present, completion_length,
      input  ready
   );
   modport sink (
      input  valid, op, queue_index, readable_length, writable_length, descriptor_index,
             header_type, header_sector, completion_id, data_present, completion_length,
      output ready
   );
endinterface
`default_nettype wire

// ===== sv/vbrt_rsp_if.sv =====
`default_nettype none
interface vbrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [63:0] request_id;
   logic [1:0]  request_kind;
   logic [63:0] request_sector;
   logic [31:0] data_length;
   logic [15:0] used_descriptor;
   logic [31:0] status_position;
   logic [1:0]  status_code;
   logic [31:0] used_length;

   modport source (
      output valid, action, request_id, request_kind, request_sector, data_length,
             used_descriptor, status_position, status_code, used_length,
      input  ready
   );
   modport sink (
      input  valid, action, request_id, request_kind, request_sector, data_length,
             used_descriptor, status_position, status_code, used_length,
      output ready
   );
endinterface
`default_nettype wire

// ===== sv/vbrt_front.sv =====
`default_nettype none
module vbrt_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   vbrt_req_if.sink                    req_bus,
   input  wire vbrt_pkg::csr_write_type csr,
   output logic                        cmd_valid,
   input  wire logic                   cmd_ready,
   output vbrt_pkg::cmd_type           cmd
);

   logic [63:0]       capacity_ff, capacity_in;
   logic              stage_valid_ff, stage_valid_in;
   vbrt_pkg::cmd_type stage_cmd_ff, stage_cmd_in;
   vbrt_pkg::cmd_type classified;

   logic                          take;
   logic                          hdr_read, hdr_write, hdr_flush;
   logic [31:0]                   dlen;
   logic [vbrt_pkg::COUNT_W-1:0]  sector_count;
   logic [64:0]                   end_sum;

   assign req_bus.ready = !stage_valid_ff || cmd_ready;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      hdr_read  = (req_bus.header_type == vbrt_pkg::HTYPE_READ);
      hdr_write = (req_bus.header_type == vbrt_pkg::HTYPE_WRITE);
      hdr_flush = (req_bus.header_type == vbrt_pkg::HTYPE_FLUSH);
      dlen = hdr_read ? (req_bus.writable_length - 32'd1)
                      : (req_bus.readable_length - vbrt_pkg::HEADER_BYTES);
      // Sector count rounded up; the carry out of the 64-bit sum counts as beyond capacity.
      sector_count = vbrt_pkg::COUNT_W'(dlen[31:vbrt_pkg::SECTOR_SHIFT])
                   + vbrt_pkg::COUNT_W'(|dlen[vbrt_pkg::SECTOR_SHIFT-1:0]);
      end_sum = {1'b0, req_bus.header_sector} + 65'(sector_count);

      classified                   = '0;
      classified.beyond            = end_sum[64] || (end_sum[63:0] > capacity_ff);
      classified.unsupported       = !(hdr_read || hdr_write || hdr_flush);
      classified.is_read           = hdr_read;
      classified.request_kind      = hdr_flush ? vbrt_pkg::KIND_FLUSH :
                                     hdr_write ? vbrt_pkg::KIND_WRITE : vbrt_pkg::KIND_READ;
      classified.sector            = req_bus.header_sector;
      classified.data_length       = dlen;
      classified.descriptor        = req_bus.descriptor_index;
      classified.status_position   = req_bus.writable_length - 32'd1;
      classified.is_fail           = (req_bus.op == vbrt_pkg::OP_FAIL);
      classified.read_data_ok      = (req_bus.op == vbrt_pkg::OP_COMPLETE_READ)
                                     && req_bus.data_present;
      classified.completion_id     = req_bus.completion_id;
      classified.completion_length = req_bus.completion_length;

      case (req_bus.op)
         vbrt_pkg::OP_SUBMIT: begin
            if (req_bus.queue_index != 4'd0
                || req_bus.readable_length < vbrt_pkg::HEADER_BYTES
                || req_bus.writable_length == 32'd0) begin
               classified.kind = vbrt_pkg::CMD_BAD_SUBMIT;
            end else begin
               classified.kind = vbrt_pkg::CMD_SUBMIT;
            end
         end
         vbrt_pkg::OP_COMPLETE_OK,
         vbrt_pkg::OP_COMPLETE_READ,
         vbrt_pkg::OP_FAIL: begin
            classified.kind = vbrt_pkg::CMD_COMPLETE;
         end
         vbrt_pkg::OP_DEVICE_RESET: begin
            classified.kind = vbrt_pkg::CMD_RESET;
         end
         default: begin
            classified.kind = vbrt_pkg::CMD_IGNORE;
         end
      endcase
   end

   always_comb begin
      capacity_in    = capacity_ff;
      stage_valid_in = stage_valid_ff && !cmd_ready;
      stage_cmd_in   = stage_cmd_ff;
      if (take) begin
         stage_valid_in = 1'b1;
         stage_cmd_in   = classified;
      end
      if (csr.enable && csr.index == vbrt_pkg::CSR_CAPACITY) begin
         capacity_in = csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         capacity_ff    <= capacity_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_cmd_ff <= stage_cmd_in;
   end

   assign cmd_valid = stage_valid_ff;
   assign cmd       = stage_cmd_ff;

endmodule
`default_nettype wire

// ===== sv/vbrt_cmd_queue.sv =====
`default_nettype none
module vbrt_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire vbrt_pkg::cmd_type push_cmd,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output vbrt_pkg::cmd_type      pop_cmd
);

   vbrt_pkg::cmd_type entries_ff [vbrt_pkg::QUEUE_DEPTH];

   logic [vbrt_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vbrt_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vbrt_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push, do_pop;

   assign push_ready = (count_ff != vbrt_pkg::QUEUE_CNT_W'(vbrt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == vbrt_pkg::QUEUE_PTR_W'(vbrt_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == vbrt_pkg::QUEUE_PTR_W'(vbrt_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== sv/vbrt_back.sv =====
`default_nettype none
module vbrt_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire vbrt_pkg::csr_write_type csr,
   input  wire logic                   cmd_valid,
   output logic                        cmd_ready,
   input  wire vbrt_pkg::cmd_type      cmd,
   vbrt_rsp_if.source                  rsp_bus
);

   logic [31:0]       device_index_ff, device_index_in;
   logic [63:0]       next_id_ff, next_id_in;
   logic              pending_valid_ff, pending_valid_in;
   logic [63:0]       pending_id_ff, pending_id_in;
   logic [15:0]       pending_desc_ff, pending_desc_in;
   logic              pending_read_ff, pending_read_in;
   logic [31:0]       pending_len_ff, pending_len_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vbrt_pkg::rsp_type rsp_ff, rsp_in;
   vbrt_pkg::rsp_type result;
   logic              advance;

   // The next command executes only while the output register is empty or being taken.
   assign advance   = cmd_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign cmd_ready = advance;

   always_comb begin
      device_index_in  = device_index_ff;
      next_id_in       = next_id_ff;
      pending_valid_in = pending_valid_ff;
      pending_id_in    = pending_id_ff;
      pending_desc_in  = pending_desc_ff;
      pending_read_in  = pending_read_ff;
      pending_len_in   = pending_len_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_bus.ready;
      rsp_in           = rsp_ff;
      result           = '0;
      result.action    = vbrt_pkg::ACT_IGNORED;

      case (cmd.kind)
         vbrt_pkg::CMD_BAD_SUBMIT: begin
            result.action = vbrt_pkg::ACT_NEEDS_RESET;
         end
         vbrt_pkg::CMD_SUBMIT: begin
            if (!pending_valid_ff) begin
               if (cmd.beyond || cmd.unsupported) begin
                  result.action          = vbrt_pkg::ACT_IMMEDIATE;
                  result.used_descriptor = cmd.descriptor;
                  result.status_position = cmd.status_position;
                  result.used_length     = 32'd1;
                  if (cmd.beyond) begin
                     result.status_code = vbrt_pkg::STATUS_IO_ERROR;
                  end else begin
                     // An unsupported request still consumes an id.
                     result.status_code = vbrt_pkg::STATUS_UNSUPPORTED;
                     if (advance) begin
                        next_id_in = next_id_ff + 64'd1;
                     end
                  end
               end else begin
                  result.action          = vbrt_pkg::ACT_EXPORTED;
                  result.request_id      = next_id_ff;
                  result.request_kind    = cmd.request_kind;
                  result.request_sector  = cmd.sector;
                  result.data_length     = cmd.data_length;
                  result.used_descriptor = cmd.descriptor;
                  result.status_position = cmd.is_read ? cmd.data_length : 32'd0;
                  if (advance) begin
                     pending_valid_in = 1'b1;
                     pending_id_in    = next_id_ff;
                     pending_desc_in  = cmd.descriptor;
                     pending_read_in  = cmd.is_read;
                     pending_len_in   = cmd.data_length;
                     next_id_in       = next_id_ff + 64'd1;
                  end
               end
            end
         end
         vbrt_pkg::CMD_COMPLETE: begin
            // A successful read must carry data of exactly the pending length.
            if (pending_valid_ff && pending_id_ff == cmd.completion_id
                && (cmd.is_fail || !pending_read_ff
                    || (cmd.read_data_ok && cmd.completion_length == pending_len_ff))) begin
               result.action          = vbrt_pkg::ACT_COMPLETED;
               result.request_id      = pending_id_ff;
               result.data_length     = pending_len_ff;
               result.used_descriptor = pending_desc_ff;
               result.status_position = pending_read_ff ? pending_len_ff : 32'd0;
               result.status_code     = cmd.is_fail ? vbrt_pkg::STATUS_IO_ERROR
                                                    : vbrt_pkg::STATUS_OK;
               result.used_length     = (!cmd.is_fail && pending_read_ff)
                                        ? cmd.completion_length + 32'd1 : 32'd1;
               if (advance) begin
                  pending_valid_in = 1'b0;
               end
            end
         end
         vbrt_pkg::CMD_RESET: begin
            result.action = vbrt_pkg::ACT_RESET_DONE;
            if (advance) begin
               pending_valid_in = 1'b0;
               pending_id_in    = '0;
               pending_desc_in  = '0;
               pending_read_in  = 1'b0;
               pending_len_in   = '0;
               next_id_in       = {device_index_ff, 32'd1};
            end
         end
         default: begin
            result.action = vbrt_pkg::ACT_IGNORED;
         end
      endcase

      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end

      if (csr.enable && csr.index == vbrt_pkg::CSR_DEVICE_INDEX) begin
         device_index_in = csr.data[31:0];
         next_id_in      = {csr.data[31:0], 32'd1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_index_ff  <= '0;
         next_id_ff       <= 64'd1;
         pending_valid_ff <= 1'b0;
         pending_id_ff    <= '0;
         pending_desc_ff  <= '0;
         pending_read_ff  <= 1'b0;
         pending_len_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         device_index_ff  <= device_index_in;
         next_id_ff       <= next_id_in;
         pending_valid_ff <= pending_valid_in;
         pending_id_ff    <= pending_id_in;
         pending_desc_ff  <= pending_desc_in;
         pending_read_ff  <= pending_read_in;
         pending_len_ff   <= pending_len_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.action          = rsp_ff.action;
   assign rsp_bus.request_id      = rsp_ff.request_id;
   assign rsp_bus.request_kind    = rsp_ff.request_kind;
   assign rsp_bus.request_sector  = rsp_ff.request_sector;
   assign rsp_bus.data_length     = rsp_ff.data_length;
   assign rsp_bus.used_descriptor = rsp_ff.used_descriptor;
   assign rsp_bus.status_position = rsp_ff.status_position;
   assign rsp_bus.status_code     = rsp_ff.status_code;
   assign rsp_bus.used_length     = rsp_ff.used_length;

endmodule
`default_nettype wire

// ===== sv/virtio_block_request_tracker.sv =====
// VirtIO block request tracker with at most one request in flight.
// The req_bus channel carries submits, completions and device resets; every
// transfer on it yields exactly one transfer on rsp_bus, in order.
// The csr_ port writes capacity_sectors (index 0) or device_index (index 1);
// writing device_index also reloads the request id counter. Write only while
// no transfer is outstanding.
// A result is registered in turn in the classifier register, the command
// queue and the executor output register before it is offered on rsp_bus.
// Throughput: one transfer per cycle on both sides while rsp_bus is ready; the
// executor consults and updates the pending request state in the same cycle.
// When rsp_bus stalls, the output register holds its result, the executor
// stops, and the queue and classifier keep taking transfers until full, at
// which point req_bus.ready drops.
// Synchronous reset clears the valid flags, the configuration registers, the
// queue and the pending request; the first request id is then 1.
`default_nettype none
module virtio_block_request_tracker (
   input  wire logic        clock,
   input  wire logic        reset,
   vbrt_req_if.sink         req_bus,
   vbrt_rsp_if.source       rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_write_data
);

   vbrt_pkg::csr_write_type csr;
   vbrt_pkg::cmd_type       front_cmd, queue_cmd;
   logic                    front_valid, front_ready;
   logic                    queue_valid, queue_ready;

   assign csr.enable = csr_write_enable;
   assign csr.index  = csr_index;
   assign csr.data   = csr_write_data;

   vbrt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr       (csr),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   vbrt_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   vbrt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== bench/vbrt_tracker_checker.sv =====
`default_nettype none
module vbrt_tracker_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   vbrt_req_if              req_bus,
   vbrt_rsp_if              rsp_bus,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_write_data,
   output logic             in_flight,
   output logic [63:0]      in_flight_id,
   output logic [31:0]      in_flight_length,
   output logic             in_flight_is_read,
   output int unsigned      results_due,
   output int unsigned      results_checked,
   output int unsigned      exports_seen,
   output int unsigned      completions_seen,
   output int unsigned      mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Far more than the block can hold between its two channels.
   localparam int unsigned EXPECT_DEPTH = 16;

   logic [63:0]       capacity_sectors;
   logic [31:0]       device_number;
   logic [63:0]       next_id;
   logic [15:0]       in_flight_descriptor;
   vbrt_pkg::rsp_type expected_ring [EXPECT_DEPTH];
   logic [3:0]        ring_head;
   logic [3:0]        ring_tail;
   int unsigned       ring_count;
   vbrt_pkg::rsp_type oldest;
   vbrt_pkg::rsp_type predicted;

   function automatic logic [63:0] first_id();
      return (64'(device_number) << vbrt_pkg::ID_SHIFT) + 64'd1;
   endfunction

   function automatic void forget_request();
      in_flight = 1'b0;
      in_flight_id = '0;
      in_flight_descriptor = '0;
      in_flight_is_read = 1'b0;
      in_flight_length = '0;
      next_id = first_id();
   endfunction

   // Works out the result of the transfer now on req_bus and advances the
   // tracker state exactly as the block should.
   function automatic vbrt_pkg::rsp_type serve_transfer();
      vbrt_pkg::rsp_type outcome;
      logic              is_read;
      logic              known_type;
      logic              beyond;
      logic              read_done;
      logic [31:0]       payload;
      logic [63:0]       sector_count;
      logic [64:0]       last_sector;
      outcome = '0;
      outcome.action = vbrt_pkg::ACT_IGNORED;
      case (req_bus.op)
         vbrt_pkg::OP_SUBMIT: begin
            is_read = req_bus.header_type == vbrt_pkg::HTYPE_READ;
            known_type = is_read || req_bus.header_type == vbrt_pkg::HTYPE_WRITE
                         || req_bus.header_type == vbrt_pkg::HTYPE_FLUSH;
            if (req_bus.queue_index != 4'd0
                || req_bus.readable_length < vbrt_pkg::HEADER_BYTES
                || req_bus.writable_length == 32'd0) begin
               outcome.action = vbrt_pkg::ACT_NEEDS_RESET;
            end else if (!in_flight) begin
               payload = is_read ? req_bus.writable_length - 32'd1
                                 : req_bus.readable_length - vbrt_pkg::HEADER_BYTES;
               sector_count = (64'(payload) + (64'd1 << vbrt_pkg::SECTOR_SHIFT) - 64'd1)
                              >> vbrt_pkg::SECTOR_SHIFT;
               last_sector = {1'b0, req_bus.header_sector} + {1'b0, sector_count};
               // A carry out of the end sector counts as past the end of the disk.
               beyond = last_sector[64] || last_sector[63:0] > capacity_sectors;
               if (beyond || !known_type) begin
                  // An unsupported type still burns an id; a range error does not.
                  if (!beyond) next_id = next_id + 64'd1;
                  outcome.action = vbrt_pkg::ACT_IMMEDIATE;
                  outcome.used_descriptor = req_bus.descriptor_index;
                  outcome.status_position = req_bus.writable_length - 32'd1;
                  outcome.status_code = beyond ? vbrt_pkg::STATUS_IO_ERROR
                                               : vbrt_pkg::STATUS_UNSUPPORTED;
                  outcome.used_length = 32'd1;
               end else begin
                  in_flight = 1'b1;
                  in_flight_id = next_id;
                  next_id = next_id + 64'd1;
                  in_flight_descriptor = req_bus.descriptor_index;
                  in_flight_is_read = is_read;
                  in_flight_length = payload;
                  outcome.action = vbrt_pkg::ACT_EXPORTED;
                  outcome.request_id = in_flight_id;
                  outcome.request_kind = is_read ? vbrt_pkg::KIND_READ
                     : (req_bus.header_type == vbrt_pkg::HTYPE_WRITE ? vbrt_pkg::KIND_WRITE
                                                                     : vbrt_pkg::KIND_FLUSH);
                  outcome.request_sector = req_bus.header_sector;
                  outcome.data_length = payload;
                  outcome.used_descriptor = req_bus.descriptor_index;
                  outcome.status_position = is_read ? payload : 32'd0;
               end
            end
         end
         vbrt_pkg::OP_COMPLETE_OK, vbrt_pkg::OP_COMPLETE_READ, vbrt_pkg::OP_FAIL: begin
            read_done = req_bus.op == vbrt_pkg::OP_COMPLETE_READ && req_bus.data_present
                        && req_bus.completion_length == in_flight_length;
            if (in_flight && in_flight_id == req_bus.completion_id
                && (req_bus.op == vbrt_pkg::OP_FAIL || !in_flight_is_read || read_done)) begin
               in_flight = 1'b0;
               outcome.action = vbrt_pkg::ACT_COMPLETED;
               outcome.request_id = in_flight_id;
               outcome.data_length = in_flight_length;
               outcome.used_descriptor = in_flight_descriptor;
               outcome.status_position = in_flight_is_read ? in_flight_length : 32'd0;
               outcome.status_code = req_bus.op == vbrt_pkg::OP_FAIL
                                     ? vbrt_pkg::STATUS_IO_ERROR : vbrt_pkg::STATUS_OK;
               outcome.used_length = (req_bus.op != vbrt_pkg::OP_FAIL && in_flight_is_read)
                                     ? in_flight_length + 32'd1 : 32'd1;
            end
         end
         vbrt_pkg::OP_DEVICE_RESET: begin
            forget_request();
            outcome.action = vbrt_pkg::ACT_RESET_DONE;
         end
         default: ;
      endcase
      return outcome;
   endfunction

   task automatic report_mismatch(input string detail);
      $display("[%0t ns] mismatch: %s", $time, detail);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s is 0x%0h, expected 0x%0h",
                                   results_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         capacity_sectors = '0;
         device_number = '0;
         forget_request();
         ring_head = '0;
         ring_tail = '0;
         ring_count = 0;
         results_checked = 0;
         exports_seen = 0;
         completions_seen = 0;
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == vbrt_pkg::CSR_CAPACITY) begin
               capacity_sectors = csr_write_data;
            end else begin
               device_number = csr_write_data[31:0];
               next_id = first_id();
            end
         end
         // Results are checked before this edge's request is predicted, so a
         // stray result can never be matched against a brand-new expectation.
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (ring_count == 0) begin
               report_mismatch($sformatf("result with action %0d and nothing outstanding",
                                         rsp_bus.action));
            end else begin
               oldest = expected_ring[ring_head];
               ring_head = ring_head + 4'd1;
               ring_count--;
               compare_field("action", 64'(rsp_bus.action), 64'(oldest.action));
               compare_field("request_id", rsp_bus.request_id, oldest.request_id);
               compare_field("request_kind", 64'(rsp_bus.request_kind),
                             64'(oldest.request_kind));
               compare_field("request_sector", rsp_bus.request_sector, oldest.request_sector);
               compare_field("data_length", 64'(rsp_bus.data_length),
                             64'(oldest.data_length));
               compare_field("used_descriptor", 64'(rsp_bus.used_descriptor),
                             64'(oldest.used_descriptor));
               compare_field("status_position", 64'(rsp_bus.status_position),
                             64'(oldest.status_position));
               compare_field("status_code", 64'(rsp_bus.status_code),
                             64'(oldest.status_code));
               compare_field("used_length", 64'(rsp_bus.used_length),
                             64'(oldest.used_length));
               if (oldest.action == vbrt_pkg::ACT_EXPORTED) exports_seen++;
               if (oldest.action == vbrt_pkg::ACT_COMPLETED) completions_seen++;
            end
            results_checked++;
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted = serve_transfer();
            if (ring_count == EXPECT_DEPTH) begin
               report_mismatch("more requests outstanding than the block can hold");
            end else begin
               expected_ring[ring_tail] = predicted;
               ring_tail = ring_tail + 4'd1;
               ring_count++;
            end
         end
      end
      results_due = ring_count;
   end

endmodule
`default_nettype wire

// ===== bench/tb_virtio_block_request_tracker.sv =====
`default_nettype none
module tb_virtio_block_request_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_PER_SETTING = 95;

   // Operation codes that the block has no use for.
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  queue_index;
      logic [31:0] readable_length;
      logic [31:0] writable_length;
      logic [15:0] descriptor_index;
      logic [31:0] header_type;
      logic [63:0] header_sector;
      logic [63:0] completion_id;
      logic        data_present;
      logic [31:0] completion_length;
   } block_request_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_RANDOM,
      READY_LONG_STALLS
   } ready_pattern_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [63:0] csr_write_data;

   logic        tracked_in_flight;
   logic [63:0] tracked_id;
   logic [31:0] tracked_length;
   logic        tracked_is_read;
   int unsigned results_due;
   int unsigned results_checked;
   int unsigned exports_seen;
   int unsigned completions_seen;
   int unsigned mismatch_count;

   logic [63:0]       disk_sectors;
   int unsigned       transfers_sent;
   int unsigned       settings_used;
   ready_pattern_type ready_pattern;
   int unsigned       pattern_left;
   int unsigned       stall_left;

   vbrt_req_if req_link ();
   vbrt_rsp_if rsp_link ();

   virtio_block_request_tracker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_link),
      .rsp_bus          (rsp_link),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   vbrt_tracker_checker tracker_check (
      .clock             (clock),
      .reset             (reset),
      .req_bus           (req_link),
      .rsp_bus           (rsp_link),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .in_flight         (tracked_in_flight),
      .in_flight_id      (tracked_id),
      .in_flight_length  (tracked_length),
      .in_flight_is_read (tracked_is_read),
      .results_due       (results_due),
      .results_checked   (results_checked),
      .exports_seen      (exports_seen),
      .completions_seen  (completions_seen),
      .mismatch_count    (mismatch_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // The result side switches at random between stall patterns: always ready, random, long stalls.
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         ready_pattern = ready_pattern_type'($urandom_range(0, 2));
         pattern_left = $urandom_range(20, 80);
      end else begin
         pattern_left--;
      end
      case (ready_pattern)
         READY_ALWAYS: rsp_link.ready <= 1'b1;
         READY_RANDOM: rsp_link.ready <= $urandom_range(0, 3) != 0;
         default: begin
            if (stall_left == 0 && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 10);
            if (stall_left != 0) begin
               stall_left--;
               rsp_link.ready <= 1'b0;
            end else begin
               rsp_link.ready <= 1'b1;
            end
         end
      endcase
   end

   function automatic block_request_type submit_of(input logic [3:0] queue,
                                                   input logic [31:0] readable,
                                                   input logic [31:0] writable,
                                                   input logic [15:0] descriptor,
                                                   input logic [31:0] header_type,
                                                   input logic [63:0] sector);
      block_request_type item;
      item = '0;
      item.op = vbrt_pkg::OP_SUBMIT;
      item.queue_index = queue;
      item.readable_length = readable;
      item.writable_length = writable;
      item.descriptor_index = descriptor;
      item.header_type = header_type;
      item.header_sector = sector;
      return item;
   endfunction

   function automatic block_request_type completion_of(input logic [2:0] op,
                                                       input logic data_present,
                                                       input logic [31:0] length,
                                                       input logic [63:0] id);
      block_request_type item;
      item = '0;
      item.op = op;
      item.data_present = data_present;
      item.completion_length = length;
      item.completion_id = id;
      return item;
   endfunction

   function automatic block_request_type control_of(input logic [2:0] op);
      block_request_type item;
      item = '0;
      item.op = op;
      return item;
   endfunction

   function automatic block_request_type fresh_submit();
      block_request_type item;
      int unsigned       pick;
      item = '0;
      item.op = vbrt_pkg::OP_SUBMIT;
      item.descriptor_index = 16'($urandom);
      item.completion_id = {$urandom, $urandom};
      item.completion_length = $urandom;
      item.data_present = 1'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         item.header_type = vbrt_pkg::HTYPE_READ;
      end else if (pick < 7) begin
         item.header_type = vbrt_pkg::HTYPE_WRITE;
      end else if (pick < 9) begin
         item.header_type = vbrt_pkg::HTYPE_FLUSH;
      end else begin
         item.header_type = $urandom;
         if (item.header_type == vbrt_pkg::HTYPE_READ
             || item.header_type == vbrt_pkg::HTYPE_WRITE
             || item.header_type == vbrt_pkg::HTYPE_FLUSH)
            item.header_type = 32'd2;
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         // Empty payload: the only kind that fits a zero-sized disk.
         item.readable_length = vbrt_pkg::HEADER_BYTES;
         item.writable_length = 32'd1;
      end else if (pick == 1) begin
         item.readable_length = $urandom;
         item.writable_length = $urandom;
         if (item.readable_length < vbrt_pkg::HEADER_BYTES)
            item.readable_length = vbrt_pkg::HEADER_BYTES;
         if (item.writable_length == 32'd0) item.writable_length = 32'd1;
      end else begin
         item.readable_length = vbrt_pkg::HEADER_BYTES + $urandom_range(0, 4096);
         item.writable_length = 32'd1 + $urandom_range(0, 4096);
      end
      if (disk_sectors[63:32] != 32'd0) begin
         if ($urandom_range(0, 3) == 0)
            item.header_sector = ~64'd0 - $urandom_range(0, 16);
         else
            item.header_sector = {$urandom, $urandom};
      end else begin
         item.header_sector = 64'($urandom_range(0, disk_sectors[31:0]))
                              + 64'($urandom_range(0, 2));
      end
      return item;
   endfunction

   // Built from the tracker's view of the request in flight, so most of
   // these retire it; the rest are near misses that must be ignored.
   function automatic block_request_type matching_completion();
      block_request_type item;
      int unsigned       pick;
      item = '0;
      item.descriptor_index = 16'($urandom);
      item.header_sector = {$urandom, $urandom};
      item.completion_id = tracked_id;
      item.data_present = 1'($urandom);
      item.completion_length = $urandom;
      pick = $urandom_range(0, 19);
      if (tracked_is_read) begin
         item.op = vbrt_pkg::OP_COMPLETE_READ;
         item.data_present = 1'b1;
         item.completion_length = tracked_length;
         if (pick < 3) item.op = vbrt_pkg::OP_FAIL;
         else if (pick == 3) item.op = vbrt_pkg::OP_COMPLETE_OK;
         else if (pick == 4) item.data_present = 1'b0;
         else if (pick == 5) item.completion_length = tracked_length + 32'd1;
      end else begin
         item.op = pick < 4 ? vbrt_pkg::OP_FAIL
                 : (pick < 12 ? vbrt_pkg::OP_COMPLETE_OK : vbrt_pkg::OP_COMPLETE_READ);
      end
      if (pick == 19) item.completion_id = tracked_id ^ (64'd1 << $urandom_range(0, 63));
      return item;
   endfunction

   function automatic block_request_type noise_request();
      block_request_type item;
      item.op = 3'($urandom_range(0, 7));
      item.queue_index = 4'($urandom);
      item.readable_length = $urandom;
      item.writable_length = $urandom;
      item.descriptor_index = 16'($urandom);
      item.header_type = $urandom;
      item.header_sector = {$urandom, $urandom};
      item.completion_id = {$urandom, $urandom};
      item.data_present = 1'($urandom);
      item.completion_length = $urandom;
      return item;
   endfunction

   // Called just after a falling edge; returns at the edge of the transfer.
   task automatic offer(input block_request_type item);
      req_link.valid <= 1'b1;
      req_link.op <= item.op;
      req_link.queue_index <= item.queue_index;
      req_link.readable_length <= item.readable_length;
      req_link.writable_length <= item.writable_length;
      req_link.descriptor_index <= item.descriptor_index;
      req_link.header_type <= item.header_type;
      req_link.header_sector <= item.header_sector;
      req_link.completion_id <= item.completion_id;
      req_link.data_present <= item.data_present;
      req_link.completion_length <= item.completion_length;
      do @(posedge clock); while (!req_link.ready);
      transfers_sent++;
   endtask

   task automatic send(input block_request_type item);
      @(negedge clock);
      offer(item);
   endtask

   task automatic pause(input int unsigned cycles);
      if (cycles != 0) begin
         @(negedge clock);
         req_link.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_link.valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic [63:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_geometry(input logic [63:0] capacity, input logic [31:0] device);
      write_register(vbrt_pkg::CSR_CAPACITY, capacity);
      // Upper bits are don't-care for the device number; toggle them anyway.
      write_register(vbrt_pkg::CSR_DEVICE_INDEX, {$urandom, device});
      disk_sectors = capacity;
      settings_used++;
   endtask

   // Expects a 2048-sector disk with device number zero.
   task automatic run_directed();
      send(control_of(vbrt_pkg::OP_DEVICE_RESET));
      send(submit_of(4'hF, 32'd100, 32'd100, 16'd1, vbrt_pkg::HTYPE_WRITE, 64'd0));
      send(submit_of(4'd0, 32'd15, 32'd100, 16'd2, vbrt_pkg::HTYPE_WRITE, 64'd0));
      send(submit_of(4'd0, 32'd16, 32'd0, 16'd3, vbrt_pkg::HTYPE_READ, 64'd0));
      send(submit_of(4'd0, 32'd16, 32'd513, 16'hFFFF, vbrt_pkg::HTYPE_READ, 64'd0));
      // Read completions that must be held back: no data, wrong length, no data
      // flag, wrong id; then a submit while busy.
      @(negedge clock);
      offer(completion_of(vbrt_pkg::OP_COMPLETE_OK, 1'b1, tracked_length, tracked_id));
      @(negedge clock);
      offer(completion_of(vbrt_pkg::OP_COMPLETE_READ, 1'b1, tracked_length + 32'd1,
                          tracked_id));
      @(negedge clock);
      offer(completion_of(vbrt_pkg::OP_COMPLETE_READ, 1'b0, tracked_length, tracked_id));
      @(negedge clock);
      offer(completion_of(vbrt_pkg::OP_COMPLETE_READ, 1'b1, tracked_length,
                          tracked_id ^ 64'd1));
      send(submit_of(4'd0, 32'd32, 32'd32, 16'd4, vbrt_pkg::HTYPE_WRITE, 64'd5));
      @(negedge clock);
      offer(completion_of(vbrt_pkg::OP_COMPLETE_READ, 1'b1, tracked_length, tracked_id));
      // A write that ends exactly at the last sector, then fails.
      send(submit_of(4'd0, 32'd1040, 32'd1, 16'd0, vbrt_pkg::HTYPE_WRITE, 64'd2046));
      @(negedge clock);
      offer(completion_of(vbrt_pkg::OP_FAIL, 1'b0, 32'd0, tracked_id));
      send(submit_of(4'd0, 32'd1040, 32'd1, 16'd7, vbrt_pkg::HTYPE_WRITE, 64'd2047));
      send(submit_of(4'd0, 32'd16, 32'd1, 16'd8, 32'hFFFF_FFFF, 64'd0));
      send(submit_of(4'd0, 32'd16, 32'd1, 16'd9, vbrt_pkg::HTYPE_FLUSH, 64'd2048));
      @(negedge clock);
      offer(completion_of(vbrt_pkg::OP_COMPLETE_READ, 1'b1, 32'hFFFF_FFFF, tracked_id));
      send(submit_of(4'd0, 32'd17, 32'd7, 16'd10, vbrt_pkg::HTYPE_WRITE, ~64'd0));
      send(control_of(OP_UNUSED_FIRST));
      send(control_of(OP_UNUSED_LAST));
      send(submit_of(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd11, vbrt_pkg::HTYPE_READ,
                     64'd0));
      send(submit_of(4'd0, 32'd16, 32'd1, 16'd12, vbrt_pkg::HTYPE_READ, 64'd0));
      // Device reset with a request still in flight drops it.
      send(control_of(vbrt_pkg::OP_DEVICE_RESET));
      send(completion_of(vbrt_pkg::OP_FAIL, 1'b0, 32'd0, 64'd3));
      send(submit_of(4'd0, 32'd16, 32'd1, 16'd13, vbrt_pkg::HTYPE_READ, 64'd2048));
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned burst_left;
      int unsigned pick;
      burst_left = 0;
      repeat (count) begin
         if (burst_left == 0) begin
            pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
         end
         burst_left--;
         @(negedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 12) offer(noise_request());
         else if (tracked_in_flight && pick >= 16) offer(matching_completion());
         else offer(fresh_submit());
      end
   endtask

   initial begin
      #5_000_000;
      $display("Timed out with %0d results still outstanding.", results_due);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = vbrt_pkg::CSR_CAPACITY;
      csr_write_data = '0;
      req_link.valid = 1'b0;
      req_link.op = vbrt_pkg::OP_SUBMIT;
      req_link.queue_index = '0;
      req_link.readable_length = '0;
      req_link.writable_length = '0;
      req_link.descriptor_index = '0;
      req_link.header_type = '0;
      req_link.header_sector = '0;
      req_link.completion_id = '0;
      req_link.data_present = 1'b0;
      req_link.completion_length = '0;
      rsp_link.ready = 1'b0;
      disk_sectors = '0;
      transfers_sent = 0;
      settings_used = 0;
      pattern_left = 0;
      stall_left = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      set_geometry(64'd2048, 32'd0);
      run_directed();
      run_random(RANDOM_PER_SETTING);
      drain();
      set_geometry(~64'd0, ~32'd0);
      run_random(RANDOM_PER_SETTING);
      drain();
      set_geometry(64'd0, 32'd1);
      run_random(RANDOM_PER_SETTING);
      drain();
      set_geometry(64'd100000, 32'h8000_0000);
      run_random(RANDOM_PER_SETTING);
      drain();

      $display("Sent %0d request transfers under %0d disk/device settings.",
               transfers_sent, settings_used);
      $display("Checked %0d results: %0d exported requests, %0d completions.",
               results_checked, exports_seen, completions_seen);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches.", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
